// ===== hdl/swbs_pkg.sv =====
// Shared types and constants for the wildcard byte signature scanner.
// No dependencies; every module of the scanner imports this package.
package swbs_pkg;

    // Size of the signature store in bytes (four 64-bit pattern words)
    localparam int unsigned SIG_BYTES       = 32;
    localparam int unsigned MAX_PATTERN_DEF = 32;
    localparam logic [7:0]  WILDCARD_BYTE   = 8'h2A;

    localparam int unsigned ADDR_W = 48;
    localparam int unsigned LEN_W  = 6;
    localparam int unsigned OFS_W  = 16;
    localparam int unsigned WORD_W = 64;
    localparam int unsigned POS_W  = 32;
    localparam int unsigned IDX_W  = 3;

    // Configuration register indexes
    localparam logic [IDX_W-1:0] REG_BASE_ADDRESS   = 3'd0;
    localparam logic [IDX_W-1:0] REG_PATTERN_LENGTH = 3'd1;
    localparam logic [IDX_W-1:0] REG_RESULT_OFFSET  = 3'd2;
    localparam logic [IDX_W-1:0] REG_PATTERN_WORD0  = 3'd3;
    localparam logic [IDX_W-1:0] REG_PATTERN_WORD1  = 3'd4;
    localparam logic [IDX_W-1:0] REG_PATTERN_WORD2  = 3'd5;
    localparam logic [IDX_W-1:0] REG_PATTERN_WORD3  = 3'd6;

    // One pending result: found flag and match start index within the region
    typedef struct packed {
        logic             found;
        logic [POS_W-1:0] start;
    } swbs_result_t;

endpackage

// ===== hdl/swbs_cell.sv =====
// One window cell of the scanner: holds one byte of the recent-byte window,
// passes it to the next cell and compares the incoming byte. Uses swbs_pkg.
module swbs_cell
    import swbs_pkg::*;
(
    input  logic       clk,
    input  logic       shift_en,
    input  logic [7:0] shift_in,
    input  logic [7:0] pattern,
    input  logic       active,
    output logic [7:0] byte_out,
    output logic       hit
);

    logic [7:0] byte_reg;

    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            byte_reg <= shift_in;
        end
    end

    assign byte_out = byte_reg;

    // Compare against the byte this cell takes on the current shift
    assign hit = !active || (pattern == WILDCARD_BYTE) || (pattern == shift_in);

endmodule

// ===== hdl/swbs_result_queue.sv =====
// Two-entry result queue between the match logic and the output channel.
// Uses swbs_pkg for the result type.
module swbs_result_queue
    import swbs_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  swbs_result_t push_data,
    input  logic         pop,
    output logic         not_full,
    output logic         not_empty,
    output swbs_result_t head
);

    logic [1:0]   count_reg;
    logic [1:0]   count_next;
    swbs_result_t head_reg;
    swbs_result_t tail_reg;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    // Payload: advance tail into head on pop, else load the pushed word
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            if (count_reg == 2'd2)
            begin
                head_reg <= tail_reg;
            end
            else if (push)
            begin
                head_reg <= push_data;
            end
        end
        else if (push && (count_reg == 2'd0))
        begin
            head_reg <= push_data;
        end
        if (push && !pop && (count_reg == 2'd1))
        begin
            tail_reg <= push_data;
        end
    end

    assign not_full  = (count_reg != 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign head      = head_reg;

endmodule

// ===== hdl/wildcard_byte_signature_scanner.sv =====
// Top level of the wildcard byte signature scanner: configuration registers,
// region control, the chain of window cells and the result queue.
// Depends on swbs_pkg, swbs_cell and swbs_result_queue.
//
//   channel  signals                                   direction  word
//   -------  ----------------------------------------  ---------  -------------------
//   input    in_valid in_ready scan_byte last_byte      in         one region byte
//   output   out_valid out_ready found match_address    out        one search result
//   config   cfg_we cfg_index cfg_data                  in         one register write
//
// One byte is taken per cycle while the result queue has room; the compare
// of the whole window against the signature happens in the cycle the byte
// is accepted, and a result passes through the queue registers to the output.
// Results pass through a two-entry queue; input ready drops only while both
// entries hold results the consumer has not taken.
// Reset (rst_n, asynchronous, active low) clears registers, position, the
// done flag and the queue; window bytes need no reset.
module wildcard_byte_signature_scanner
    import swbs_pkg::*;
#(
    parameter int unsigned MAX_PATTERN = MAX_PATTERN_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,

    input  logic              in_valid,
    output logic              in_ready,
    input  logic [7:0]        scan_byte,
    input  logic              last_byte,

    output logic              out_valid,
    input  logic              out_ready,
    output logic              found,
    output logic [ADDR_W-1:0] match_address,

    input  logic              cfg_we,
    input  logic [IDX_W-1:0]  cfg_index,
    input  logic [WORD_W-1:0] cfg_data
);

    // Only the cells a signature can reach are built
    localparam int unsigned NCELL = (MAX_PATTERN < SIG_BYTES) ? MAX_PATTERN : SIG_BYTES;
    localparam int unsigned SIG_W = SIG_BYTES * 8;

    // Configuration registers
    logic [ADDR_W-1:0] base_reg;
    logic [LEN_W-1:0]  len_reg;
    logic [OFS_W-1:0]  offset_reg;
    logic [WORD_W-1:0] word0_reg;
    logic [WORD_W-1:0] word1_reg;
    logic [WORD_W-1:0] word2_reg;
    logic [WORD_W-1:0] word3_reg;

    // Region state
    logic [POS_W-1:0]  pos_reg;
    logic [POS_W-1:0]  pos_next;
    logic              done_reg;
    logic              done_next;

    logic              accept;
    logic              shift_en;
    logic [POS_W-1:0]  pos_inc;
    logic              cfg_ok;
    logic              window_hit;
    logic              match;
    logic              push;
    swbs_result_t      push_data;
    swbs_result_t      head;
    logic              q_not_full;

    logic [SIG_W-1:0]  sig_vec;
    logic [SIG_W-1:0]  sig_rev;
    logic [SIG_W-1:0]  sig_aligned;
    logic [LEN_W-1:0]  align_sh;
    logic [NCELL-1:0]  cell_hit;
    logic [7:0]        chain [NCELL+1];

    //------------------------------------------------------------------
    // Configuration port: write on enable, ignore unused indexes
    //------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg   <= '0;
            len_reg    <= '0;
            offset_reg <= '0;
            word0_reg  <= '0;
            word1_reg  <= '0;
            word2_reg  <= '0;
            word3_reg  <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_BASE_ADDRESS:   base_reg   <= cfg_data[ADDR_W-1:0];
                REG_PATTERN_LENGTH: len_reg    <= cfg_data[LEN_W-1:0];
                REG_RESULT_OFFSET:  offset_reg <= cfg_data[OFS_W-1:0];
                REG_PATTERN_WORD0:  word0_reg  <= cfg_data;
                REG_PATTERN_WORD1:  word1_reg  <= cfg_data;
                REG_PATTERN_WORD2:  word2_reg  <= cfg_data;
                REG_PATTERN_WORD3:  word3_reg  <= cfg_data;
                default:            ;
            endcase
        end
    end

    //------------------------------------------------------------------
    // Signature alignment. Cell j compares the byte received j bytes ago and
    // must meet signature byte len-1-j. Reverse the signature store and
    // shift it down by 32-len bytes so that byte j of the result lines up
    // with cell j. This depends on configuration only.
    //------------------------------------------------------------------
    assign sig_vec = {word3_reg, word2_reg, word1_reg, word0_reg};

    for (genvar k = 0; k < SIG_BYTES; k++)
    begin : g_rev
        assign sig_rev[8*k +: 8] = sig_vec[8*(SIG_BYTES-1-k) +: 8];
    end

    assign align_sh    = LEN_W'(SIG_BYTES) - len_reg;
    assign sig_aligned = sig_rev >> {align_sh[LEN_W-2:0], 3'b000};

    // Base address and length must be nonzero; length must fit both the store and the window
    assign cfg_ok = (base_reg != '0) && (len_reg != '0)
                    && ({1'b0, len_reg} <= 7'(SIG_BYTES))
                    && ({1'b0, len_reg} <= 7'(MAX_PATTERN));

    //------------------------------------------------------------------
    // Window: chain of cells, newest byte enters cell 0. Hold the chain
    // once a match is reported; later bytes of the region are dropped.
    //------------------------------------------------------------------
    assign accept   = in_valid && in_ready;
    assign shift_en = accept && !done_reg;
    assign chain[0] = scan_byte;

    for (genvar j = 0; j < NCELL; j++)
    begin : g_cell
        swbs_cell u_cell (
            .clk      (clk),
            .shift_en (shift_en),
            .shift_in (chain[j]),
            .pattern  (sig_aligned[8*j +: 8]),
            .active   (len_reg > LEN_W'(j)),
            .byte_out (chain[j+1]),
            .hit      (cell_hit[j])
        );
    end

    assign window_hit = &cell_hit;

    //------------------------------------------------------------------
    // Region control: position counts bytes (saturating), a match needs
    // at least len bytes seen in this region.
    //------------------------------------------------------------------
    assign pos_inc = (pos_reg == '1) ? pos_reg : pos_reg + POS_W'(1);
    assign match   = cfg_ok && window_hit && (pos_inc >= POS_W'(len_reg));

    always_comb
    begin
        pos_next        = pos_reg;
        done_next       = done_reg;
        push            = 1'b0;
        push_data.found = 1'b0;
        push_data.start = '0;
        if (accept)
        begin
            if (done_reg)
            begin
                // Drop bytes after a match; the final byte ends the region
                if (last_byte)
                begin
                    pos_next  = '0;
                    done_next = 1'b0;
                end
            end
            else
            begin
                pos_next = pos_inc;
                if (match)
                begin
                    push            = 1'b1;
                    push_data.found = 1'b1;
                    push_data.start = pos_inc - POS_W'(len_reg);
                end
                else if (last_byte)
                begin
                    push = 1'b1;
                end
                if (last_byte)
                begin
                    pos_next  = '0;
                    done_next = 1'b0;
                end
                else if (match)
                begin
                    done_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            pos_reg  <= pos_next;
            done_reg <= done_next;
        end
    end

    //------------------------------------------------------------------
    // Result queue and output. Configuration must stay fixed while results
    // wait (the block does not enforce this): the address is formed from the queued start index.
    //------------------------------------------------------------------
    swbs_result_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (out_valid && out_ready),
        .not_full  (q_not_full),
        .not_empty (out_valid),
        .head      (head)
    );

    assign in_ready      = q_not_full;
    assign found         = head.found;
    assign match_address = head.found
                           ? (base_reg + ADDR_W'(head.start) + ADDR_W'(offset_reg))
                           : '0;

endmodule
